### hw/rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment scan driver
// Command codes, the queued command record, glyph table and digit helpers.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int NUM_DIGITS = 6;                 // 1..8
  localparam int POS_W      = 3;                 // digit_select width
  localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [POS_W:0] NUM_DIGITS_W = (POS_W + 1)'(NUM_DIGITS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_DIGITS - 1);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // floor(v/10) = (v * RECIP10) >> RECIP_SHIFT for any 32-bit v
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] DP_BIT     = 8'h80;
  localparam int         GLYPH_CNT  = 32;

  typedef enum logic [2:0] {
    MODE_SCAN   = 3'd0,
    MODE_UPDATE = 3'd1,
    MODE_DP     = 3'd2,
    MODE_TICK   = 3'd3,
    MODE_SPLASH = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t       kind;
    logic [31:0] value;
    logic [7:0]  dp_timeout;
    logic [5:0]  dp_mask;
    logic [2:0]  splash_index;
    logic [7:0]  splash_code;
    logic        splash_active;
  } cmd_t;

  localparam logic [6:0] GLYPHS [GLYPH_CNT] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71,
    7'h7D, 7'h76, 7'h06, 7'h1E, 7'h38, 7'h54, 7'h73, 7'h67,
    7'h50, 7'h6D, 7'h78, 7'h3E, 7'h00, 7'h40, 7'h3F, 7'h1C
  };

  // codes 32 and up are blank
  function automatic logic [7:0] glyph(input logic [7:0] code);
    logic [7:0] seg;
    seg = 8'h00;
    if (code < 8'(GLYPH_CNT)) begin
      seg = {1'b0, GLYPHS[code[4:0]]};
    end
    return seg;
  endfunction

endpackage

### hw/rtl/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front: command intake
// Decodes the mode, drops no-op commands and packs the rest for the queue.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic               push,
  output logic               full,
  input  logic [2:0]         mode,
  input  logic [31:0]        value,
  input  logic [7:0]         dp_timeout,
  input  logic [5:0]         dp_mask,
  input  logic [2:0]         splash_index,
  input  logic [7:0]         splash_code,
  input  logic               splash_active,
  input  logic               q_full,
  output logic               q_push,
  output ssd_pkg::cmd_t      q_entry
);

  logic keep;

  always_comb begin
    keep = 1'b0;
    case (mode)
      ssd_pkg::MODE_SCAN,
      ssd_pkg::MODE_UPDATE,
      ssd_pkg::MODE_DP,
      ssd_pkg::MODE_TICK:   keep = 1'b1;
      ssd_pkg::MODE_SPLASH: keep = ({1'b0, splash_index} < ssd_pkg::NUM_DIGITS_W);
      default:              keep = 1'b0;   // unused modes do nothing
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

  always_comb begin
    q_entry.kind          = ssd_pkg::mode_t'(mode);
    q_entry.value         = value;
    q_entry.dp_timeout    = dp_timeout;
    q_entry.dp_mask       = dp_mask;
    q_entry.splash_index  = splash_index;
    q_entry.splash_code   = splash_code;
    q_entry.splash_active = splash_active;
  end

endmodule

### hw/rtl/ssd_cmd_queue.sv
// ----------------------------------------------------------------------------
// ssd_cmd_queue: command queue between intake and execution
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ssd_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ssd_pkg::cmd_t      push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output ssd_pkg::cmd_t      head
);

  ssd_pkg::cmd_t                  slots [ssd_pkg::CQ_DEPTH];
  logic [ssd_pkg::CQ_PTR_W-1:0]   wr_ptr;
  logic [ssd_pkg::CQ_PTR_W-1:0]   rd_ptr;
  logic [ssd_pkg::CQ_CNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count == ssd_pkg::CQ_CNT_W'(ssd_pkg::CQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + ssd_pkg::CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + ssd_pkg::CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + ssd_pkg::CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - ssd_pkg::CQ_CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back: command execution
// Holds display state, splits values into decimal digits one per cycle,
// and renders scan results into a two-entry result buffer.
// ----------------------------------------------------------------------------
module ssd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  ssd_pkg::cmd_t             head,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                segments,
  output logic [ssd_pkg::POS_W-1:0] digit_select
);

  logic [3:0]                  digits [ssd_pkg::NUM_DIGITS];
  logic [7:0]                  splash [ssd_pkg::NUM_DIGITS];
  logic [ssd_pkg::POS_W-1:0]   scan_position;
  logic [7:0]                  dp_countdown;
  logic [5:0]                  dp_digit_mask;

  // digit splitter
  logic                        conv_busy;
  logic [31:0]                 conv_value;
  logic [ssd_pkg::IDX_W-1:0]   conv_idx;
  logic [63:0]                 prod;
  logic [31:0]                 quot;
  logic [31:0]                 rem;

  // result buffer
  logic [7:0]                  ob_seg [2];
  logic [ssd_pkg::POS_W-1:0]   ob_sel [2];
  logic                        ob_wr;
  logic                        ob_rd;
  logic [1:0]                  ob_count;
  logic                        ob_push;
  logic                        ob_pop;

  // scan rendering
  logic [ssd_pkg::POS_W-1:0]   pos;
  logic [ssd_pkg::POS_W-1:0]   pos_next;
  logic [ssd_pkg::IDX_W-1:0]   pos_idx;
  logic [7:0]                  code;
  logic [7:0]                  mask_ext;
  logic [7:0]                  seg;

  assign prod = 64'(conv_value) * 64'(ssd_pkg::RECIP10);
  assign quot = 32'(prod >> ssd_pkg::RECIP_SHIFT);
  assign rem  = conv_value - ((quot << 3) + (quot << 1));

  always_comb begin
    pos = scan_position;
    if ({1'b0, scan_position} >= ssd_pkg::NUM_DIGITS_W) begin
      pos = '0;
    end
    pos_idx  = pos[ssd_pkg::IDX_W-1:0];
    pos_next = pos + ssd_pkg::POS_W'(1);
    if ({1'b0, pos_next} >= ssd_pkg::NUM_DIGITS_W) begin
      pos_next = '0;
    end
    code = head.splash_active ? splash[pos_idx] : {4'b0, digits[pos_idx]};
    mask_ext = {2'b0, dp_digit_mask};
    seg = ssd_pkg::glyph(code);
    if (dp_countdown != 8'd0 && mask_ext[pos]) begin
      seg = seg | ssd_pkg::DP_BIT;
    end
  end

  assign q_pop   = head_valid && !conv_busy &&
                   (head.kind != ssd_pkg::MODE_SCAN || ob_count != 2'd2);
  assign ob_push = q_pop && head.kind == ssd_pkg::MODE_SCAN;
  assign ob_pop  = pop && ob_count != 2'd0;

  assign empty        = (ob_count == 2'd0);
  assign segments     = ob_seg[ob_rd];
  assign digit_select = ob_sel[ob_rd];

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_seg[ob_wr] <= seg;
      ob_sel[ob_wr] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
      dp_countdown  <= '0;
      dp_digit_mask <= '0;
      conv_busy     <= 1'b0;
      conv_value    <= '0;
      conv_idx      <= '0;
      ob_wr         <= 1'b0;
      ob_rd         <= 1'b0;
      ob_count      <= 2'd0;
      for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
        digits[i] <= '0;
        splash[i] <= '0;
      end
    end else begin
      if (conv_busy) begin
        digits[conv_idx] <= rem[3:0];
        conv_value       <= quot;
        conv_idx         <= conv_idx + ssd_pkg::IDX_W'(1);
        if (conv_idx == ssd_pkg::LAST_IDX) begin
          conv_busy <= 1'b0;
        end
      end

      if (q_pop) begin
        case (head.kind)
          ssd_pkg::MODE_SCAN: begin
            scan_position <= pos_next;
          end
          ssd_pkg::MODE_UPDATE: begin
            conv_busy  <= 1'b1;
            conv_value <= head.value;
            conv_idx   <= '0;
          end
          ssd_pkg::MODE_DP: begin
            dp_countdown  <= head.dp_timeout;
            dp_digit_mask <= head.dp_mask;
          end
          ssd_pkg::MODE_TICK: begin
            if (dp_countdown != 8'd0) begin
              dp_countdown <= dp_countdown - 8'd1;
            end
          end
          ssd_pkg::MODE_SPLASH: begin
            splash[head.splash_index[ssd_pkg::IDX_W-1:0]] <= head.splash_code;
          end
          default: begin
          end
        endcase
      end

      if (ob_push) begin
        ob_wr <= ~ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= ~ob_rd;
      end
      if (ob_push && !ob_pop) begin
        ob_count <= ob_count + 2'd1;
      end else if (ob_pop && !ob_push) begin
        ob_count <= ob_count - 2'd1;
      end
    end
  end

endmodule

### hw/rtl/seven_segment_scan_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top: multiplexed six-digit display driver
// Queue-style command port in, queue-style segment/digit results out.
// ----------------------------------------------------------------------------
// Commands are taken one per clock whenever full is low. The intake decodes
// each command and drops the ones that do nothing (unused modes, splash writes
// to a position past the last digit); the rest wait in a four-entry command
// queue. The execution side retires one command per cycle, with two
// exceptions: a value update holds it while the decimal digits are peeled off
// one per cycle through a 32x32 reciprocal multiply, and a scan waits while
// both result slots are occupied. Commands arriving meanwhile fill the queue,
// and full rises once it holds four. Each scan yields exactly one result; it
// is registered in the command queue and then in the result buffer before it
// shows on the result ports, and a result holds on segments/digit_select
// while empty is low until popped. A scan issued after an update sees all the
// new digits.
module seven_segment_scan_driver_top (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode,
  input  logic [31:0] value,
  input  logic [7:0]  dp_timeout,
  input  logic [5:0]  dp_mask,
  input  logic [2:0]  splash_index,
  input  logic [7:0]  splash_code,
  input  logic        splash_active,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  segments,
  output logic [2:0]  digit_select
);

  ssd_pkg::cmd_t q_entry;
  ssd_pkg::cmd_t q_head;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;

  // intake: decode and filter
  ssd_front u_front (
    .push          (push),
    .full          (full),
    .mode          (mode),
    .value         (value),
    .dp_timeout    (dp_timeout),
    .dp_mask       (dp_mask),
    .splash_index  (splash_index),
    .splash_code   (splash_code),
    .splash_active (splash_active),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // decouples intake from execution
  ssd_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // execution: display state, digit split, result buffer
  ssd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_valid),
    .head         (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .segments     (segments),
    .digit_select (digit_select)
  );

endmodule

### bench/ssd_scan_checker.sv
// ----------------------------------------------------------------------------
// ssd_scan_checker: prediction and comparison for the seven-segment scan driver
// Watches both queue ports. It keeps its own copy of the display state and
// queues one expected digit per scan command. Each popped result is compared
// field by field with the oldest expected digit.
// ----------------------------------------------------------------------------
module ssd_scan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  mode,
  input  logic [31:0] value,
  input  logic [7:0]  dp_timeout,
  input  logic [5:0]  dp_mask,
  input  logic [2:0]  splash_index,
  input  logic [7:0]  splash_code,
  input  logic        splash_active,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  segments,
  input  logic [2:0]  digit_select,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] seg;
    logic [2:0] pos;
  } lit_digit_t;

  // segment font, bit0 = a .. bit6 = g
  localparam logic [7:0] FONT [32] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
    8'h7D, 8'h76, 8'h06, 8'h1E, 8'h38, 8'h54, 8'h73, 8'h67,
    8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h40, 8'h3F, 8'h1C
  };

  lit_digit_t expected_digits[$];
  logic [2:0] scan_pos;
  logic [3:0] digit_val  [ssd_pkg::NUM_DIGITS];
  logic [7:0] splash_val [ssd_pkg::NUM_DIGITS];
  logic [7:0] dp_left;
  logic [5:0] dp_sel;

  // one line per mismatch, and count it
  task automatic flag(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    lit_digit_t want;
    logic [31:0] v;
    logic [7:0]  code;
    if (rst) begin
      expected_digits.delete();
      scan_pos = '0;
      foreach (digit_val[i]) begin
        digit_val[i]  = '0;
        splash_val[i] = '0;
      end
      dp_left = '0;
      dp_sel  = '0;
    end else begin
      // result side first: a transfer in cannot show up on the same edge
      if (pop && !empty) begin
        if (expected_digits.size() == 0) begin
          flag($sformatf("result with nothing expected: seg %02h digit %0d",
                         segments, digit_select));
        end else begin
          want = expected_digits.pop_front();
          if (segments !== want.seg) begin
            flag($sformatf("segments %02h, want %02h (digit %0d)",
                           segments, want.seg, want.pos));
          end
          if (digit_select !== want.pos) begin
            flag($sformatf("digit_select %0d, want %0d", digit_select, want.pos));
          end
        end
      end
      if (push && !full) begin
        case (mode)
          ssd_pkg::MODE_UPDATE: begin
            v = value;
            for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
              digit_val[i] = 4'(v % 10);
              v = v / 10;
            end
          end
          ssd_pkg::MODE_DP: begin
            dp_left = dp_timeout;
            dp_sel  = dp_mask;
          end
          ssd_pkg::MODE_TICK: begin
            if (dp_left != 0) dp_left = dp_left - 8'd1;
          end
          ssd_pkg::MODE_SPLASH: begin
            if (splash_index < ssd_pkg::NUM_DIGITS) splash_val[splash_index] = splash_code;
          end
          ssd_pkg::MODE_SCAN: begin
            code = splash_active ? splash_val[scan_pos] : 8'(digit_val[scan_pos]);
            want.seg = (code < 8'd32) ? FONT[code[4:0]] : 8'h00;
            if (dp_left != 0 && dp_sel[scan_pos]) want.seg |= ssd_pkg::DP_BIT;
            want.pos = scan_pos;
            expected_digits.push_back(want);
            scan_pos = (scan_pos == 3'(ssd_pkg::NUM_DIGITS - 1)) ? 3'd0
                                                                 : scan_pos + 3'd1;
          end
          default: ;
        endcase
      end
    end
    pending = expected_digits.size();
  end

endmodule

### bench/tb_seven_segment_scan_driver_top.sv
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_driver_top: stimulus and verdict for the scan driver
// Directed commands over the field extremes and corner cases, then about a
// thousand weighted random commands with random idling on both queue ports.
// Prediction and checking live in ssd_scan_checker.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_driver_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Random commands that change something; directed part adds about 25.
  localparam int RANDOM_ITEMS = 1025;
  // Slowest honest run: ~1050 transfers, each with its idle gap, an update and
  // a long pop stall, stays well within this limit.
  localparam int LIMIT_CYCLES = 400000;
  // Spare mode codes: the block drops them at intake.
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [7:0]  dp_timeout;
    logic [5:0]  dp_mask;
    logic [2:0]  splash_index;
    logic [7:0]  splash_code;
    logic        splash_active;
  } ssd_cmd_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  mode;
  logic [31:0] value;
  logic [7:0]  dp_timeout;
  logic [5:0]  dp_mask;
  logic [2:0]  splash_index;
  logic [7:0]  splash_code;
  logic        splash_active;
  logic        empty;
  logic        pop;
  logic [7:0]  segments;
  logic [2:0]  digit_select;

  int fail_count;
  int pending;
  int cycles;
  // high during a long window of the random part: neither side idles then
  logic calm;

  seven_segment_scan_driver_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .value        (value),
    .dp_timeout   (dp_timeout),
    .dp_mask      (dp_mask),
    .splash_index (splash_index),
    .splash_code  (splash_code),
    .splash_active(splash_active),
    .empty        (empty),
    .pop          (pop),
    .segments     (segments),
    .digit_select (digit_select)
  );

  ssd_scan_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .value        (value),
    .dp_timeout   (dp_timeout),
    .dp_mask      (dp_mask),
    .splash_index (splash_index),
    .splash_code  (splash_code),
    .splash_active(splash_active),
    .empty        (empty),
    .pop          (pop),
    .segments     (segments),
    .digit_select (digit_select),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard: a hang on either handshake ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("seven_segment_scan_driver_top: mismatch");
      $finish;
    end
  end

  // A command of the given mode with every other field random; the block
  // must ignore whatever the mode does not use.
  function automatic ssd_cmd_t make_cmd(input logic [2:0] m);
    ssd_cmd_t c;
    c.mode          = m;
    c.value         = $urandom;
    c.dp_timeout    = 8'($urandom);
    c.dp_mask       = 6'($urandom);
    c.splash_index  = 3'($urandom);
    c.splash_code   = 8'($urandom);
    c.splash_active = 1'($urandom);
    return c;
  endfunction

  // Weighted mix: scans most often, with enough updates, decimal-point commands
  // and ticks that the countdown actually runs out between scans.
  function automatic ssd_cmd_t random_cmd();
    ssd_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      c = make_cmd(ssd_pkg::MODE_SCAN);
    end else if (pick < 58) begin
      c = make_cmd(ssd_pkg::MODE_UPDATE);
      case ($urandom_range(3))
        0: c.value = $urandom_range(999_999);
        1: c.value = $urandom_range(99);
        2: begin
          case ($urandom_range(3))
            0: c.value = 32'd0;
            1: c.value = 32'd999_999;
            2: c.value = 32'd1_000_000;
            default: c.value = 32'hFFFF_FFFF;
          endcase
        end
        default: ; // full 32-bit random
      endcase
    end else if (pick < 66) begin
      c = make_cmd(ssd_pkg::MODE_DP);
      if ($urandom_range(3) != 0) c.dp_timeout = 8'($urandom_range(0, 6));
    end else if (pick < 83) begin
      c = make_cmd(ssd_pkg::MODE_TICK);
    end else if (pick < 96) begin
      c = make_cmd(ssd_pkg::MODE_SPLASH);
      // now and then a write past the last digit, which must be dropped
      c.splash_index = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(5));
      if ($urandom_range(3) != 0) c.splash_code = 8'($urandom_range(31));
    end else begin
      c = make_cmd(3'($urandom_range(5, 7)));
    end
    return c;
  endfunction

  // One transfer in. Fields hold while full keeps the push waiting. Returns
  // at the falling edge after the transfer, where the next one may start.
  task automatic send_cmd(input ssd_cmd_t c);
    if (!calm && $urandom_range(99) < 11) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push          <= 1'b1;
    mode          <= c.mode;
    value         <= c.value;
    dp_timeout    <= c.dp_timeout;
    dp_mask       <= c.dp_mask;
    splash_index  <= c.splash_index;
    splash_code   <= c.splash_code;
    splash_active <= c.splash_active;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender holds off until the driver has handed out every expected digit.
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: pop goes low at random, mostly in short stalls, sometimes in
  // a long one so the result slots and command queue back up.
  initial begin : pop_side
    int hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(99) < 9) begin
        pop <= 1'b0;
        hold = ($urandom_range(49) == 0) ? 20 : $urandom_range(3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    ssd_cmd_t c;
    int       sent;
    bit       paused;
    rst           = 1'b1;
    push          = 1'b0;
    mode          = '0;
    value         = '0;
    dp_timeout    = '0;
    dp_mask       = '0;
    splash_index  = '0;
    splash_code   = '0;
    splash_active = 1'b0;
    calm          = 1'b0;
    cycles        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // scan straight out of reset: digit 0 reads zero, no decimal point
    c = make_cmd(ssd_pkg::MODE_SCAN);
    c.splash_active = 1'b0;
    send_cmd(c);
    // largest value: only 967295 survives
    c = make_cmd(ssd_pkg::MODE_UPDATE);
    c.value = 32'hFFFF_FFFF;
    send_cmd(c);
    // decimal points on alternate digits for two ticks
    c = make_cmd(ssd_pkg::MODE_DP);
    c.dp_timeout = 8'd2;
    c.dp_mask    = 6'b101010;
    send_cmd(c);
    // one full sweep including the wrap from the top digit back to units
    repeat (ssd_pkg::NUM_DIGITS) begin
      c = make_cmd(ssd_pkg::MODE_SCAN);
      c.splash_active = 1'b0;
      send_cmd(c);
    end
    // third tick lands on a countdown already at zero
    repeat (3) send_cmd(make_cmd(ssd_pkg::MODE_TICK));
    c = make_cmd(ssd_pkg::MODE_SCAN);
    c.splash_active = 1'b0;
    send_cmd(c);
    // splash: largest code (blank), last glyph, first blank code, and a
    // write past the last digit that has to be dropped
    c = make_cmd(ssd_pkg::MODE_SPLASH);
    c.splash_index = 3'd0;
    c.splash_code  = 8'd255;
    send_cmd(c);
    c = make_cmd(ssd_pkg::MODE_SPLASH);
    c.splash_index = 3'(ssd_pkg::NUM_DIGITS - 1);
    c.splash_code  = 8'd31;
    send_cmd(c);
    c = make_cmd(ssd_pkg::MODE_SPLASH);
    c.splash_index = 3'd1;
    c.splash_code  = 8'd32;
    send_cmd(c);
    c = make_cmd(ssd_pkg::MODE_SPLASH);
    c.splash_index = 3'd7;
    c.splash_code  = 8'hA5;
    send_cmd(c);
    // spare mode: no effect, no result
    send_cmd(make_cmd(MODE_SPARE7));
    send_cmd(make_cmd(MODE_SPARE5));
    // longest countdown, every decimal point, blank digits keep the point
    c = make_cmd(ssd_pkg::MODE_DP);
    c.dp_timeout = 8'd255;
    c.dp_mask    = 6'h3F;
    send_cmd(c);
    repeat (ssd_pkg::NUM_DIGITS) begin
      c = make_cmd(ssd_pkg::MODE_SCAN);
      c.splash_active = 1'b1;
      send_cmd(c);
    end

    drain_results();

    // ---- random part ----
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      calm <= (sent >= 400 && sent < 560);
      c = random_cmd();
      send_cmd(c);
      // dropped commands do not count toward the total
      if (c.mode <= ssd_pkg::MODE_SPLASH &&
          !(c.mode == ssd_pkg::MODE_SPLASH && c.splash_index >= ssd_pkg::NUM_DIGITS)) begin
        sent++;
      end
      if (!paused && sent >= 750) begin
        paused = 1'b1;
        drain_results();
      end
    end

    // ---- wind down ----
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // a late or extra result would surface during this wait
    repeat (4 * ssd_pkg::NUM_DIGITS) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("seven_segment_scan_driver_top: match");
    end else begin
      $display("seven_segment_scan_driver_top: mismatch");
    end
    $finish;
  end

endmodule
